### hw/rtl/sha256_bh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash package
// Shared widths, the initial hash value, the round constant table, the
// round and schedule functions, and the types that pass between the units.
// ----------------------------------------------------------------------------
package sha256_bh_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned BlockWords    = 16;
  localparam int unsigned DigestWords   = 8;
  localparam int unsigned Rounds        = 64;
  localparam int unsigned WidxW         = $clog2(BlockWords);
  localparam int unsigned RoundW        = $clog2(Rounds);
  localparam int unsigned BlkQueueDepth = 2;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [WidxW-1:0]  widx_t;
  typedef logic [RoundW-1:0] round_t;
  typedef logic [DigestWords-1:0][WordW-1:0] digest_t;

  localparam word_t InitValue [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_s0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_s0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch_fn(word_t e, word_t f, word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj_fn(word_t a, word_t b, word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  typedef enum logic [1:0] {
    CoreIdle,
    CoreRun,
    CoreAdd
  } core_state_e;

  // Front to queue: word writes and block push.
  typedef struct packed {
    logic  wr_en;
    widx_t wr_widx;
    word_t wr_data;
    logic  push;
    logic  push_final;
  } q_wr_t;

  // Core to queue: word reads and block pop.
  typedef struct packed {
    logic  rd_en;
    widx_t rd_widx;
    logic  pop;
  } q_rd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
    logic head_final;
  } q_stat_t;

endpackage

### hw/rtl/sha256_bh_if.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash channels
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sha256_bh_in_if;
  logic                       valid;
  logic                       ready;
  logic [31:0]                message_word;
  logic                       final_block;

  modport source (output valid, output message_word, output final_block, input ready);
  modport sink   (input valid, input message_word, input final_block, output ready);
endinterface

interface sha256_bh_out_if;
  logic                       valid;
  logic                       ready;
  logic [31:0]                digest_word;
  logic                       last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

### hw/rtl/sha256_bh_front.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash front end
// Accepts message words, places them in the free queue slot and pushes the
// slot with its final flag once the sixteenth word is in.
// ----------------------------------------------------------------------------
module sha256_bh_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sha256_bh_in_if.sink           msg_i,
  input  sha256_bh_pkg::q_stat_t q_stat_i,
  output sha256_bh_pkg::q_wr_t   q_wr_o
);
  import sha256_bh_pkg::*;

  widx_t widx_q, widx_d;
  logic  accept;

  assign msg_i.ready = ~q_stat_i.full;
  assign accept      = msg_i.valid & msg_i.ready;

  // Index wraps naturally at the block size.
  assign widx_d = accept ? widx_q + widx_t'(1) : widx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
    end else begin
      widx_q <= widx_d;
    end
  end

  always_comb begin
    q_wr_o.wr_en      = accept;
    q_wr_o.wr_widx    = widx_q;
    q_wr_o.wr_data    = msg_i.message_word;
    // Only the flag on the last word of a block counts.
    q_wr_o.push       = accept && (widx_q == widx_t'(BlockWords - 1));
    q_wr_o.push_final = msg_i.final_block;
  end

endmodule

### hw/rtl/sha256_bh_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash queue
// Block slots in one word-wide memory, filled by the front end word by word
// and read back one word per cycle by the compression core.
// ----------------------------------------------------------------------------
module sha256_bh_queue #(
  parameter int unsigned Depth = sha256_bh_pkg::BlkQueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_bh_pkg::q_wr_t   q_wr_i,
  input  sha256_bh_pkg::q_rd_t   q_rd_i,
  output sha256_bh_pkg::q_stat_t q_stat_o,
  output sha256_bh_pkg::word_t   rd_data_o
);
  import sha256_bh_pkg::*;

  localparam int unsigned SlotW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned Words = Depth * BlockWords;

  typedef logic [SlotW-1:0] slot_t;

  word_t            mem_q [Words];
  word_t            rd_data_q;
  logic [Depth-1:0] final_q;
  slot_t            wr_ptr_q, wr_ptr_d;
  slot_t            rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic slot_t next_slot(slot_t p);
    return (p == slot_t'(Depth - 1)) ? '0 : p + slot_t'(1);
  endfunction

  always_comb begin
    wr_ptr_d = q_wr_i.push ? next_slot(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = q_rd_i.pop ? next_slot(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (q_wr_i.push && !q_rd_i.pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (q_rd_i.pop && !q_wr_i.push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_wr_i.wr_en) begin
      mem_q[{wr_ptr_q, q_wr_i.wr_widx}] <= q_wr_i.wr_data;
    end
    if (q_rd_i.rd_en) begin
      rd_data_q <= mem_q[{rd_ptr_q, q_rd_i.rd_widx}];
    end
    if (q_wr_i.push) begin
      final_q[wr_ptr_q] <= q_wr_i.push_final;
    end
  end

  assign rd_data_o           = rd_data_q;
  assign q_stat_o.full       = (cnt_q == CntW'(Depth));
  assign q_stat_o.not_empty  = (cnt_q != '0);
  assign q_stat_o.head_final = final_q[rd_ptr_q];

endmodule

### hw/rtl/sha256_bh_core.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash compression core
// Runs one round per cycle, each schedule word made in the cycle before its
// round, then adds the working variables into the chaining value.
// ----------------------------------------------------------------------------
module sha256_bh_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_bh_pkg::q_stat_t q_stat_i,
  input  sha256_bh_pkg::word_t   rd_data_i,
  output sha256_bh_pkg::q_rd_t   q_rd_o,
  input  logic                   out_free_i,
  output logic                   out_load_o,
  output sha256_bh_pkg::digest_t digest_o
);
  import sha256_bh_pkg::*;

  localparam int unsigned CntW = $clog2(Rounds + 1);

  core_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            final_q;
  word_t           chain_q [DigestWords];
  word_t           v_q [DigestWords];
  word_t           win_q [BlockWords];
  word_t           w_q;
  word_t           w_new;
  word_t           t1;
  word_t           t2;
  word_t           sum [DigestWords];
  logic [CntW-1:0] round_cnt;
  round_t          round_idx;
  logic            start;

  // Window holds w[t-16] at index 0 up to w[t-1] at the top.
  assign w_new = (cnt_q < CntW'(BlockWords)) ? rd_data_i
               : small_s1(win_q[BlockWords-2]) + win_q[BlockWords-7]
                 + small_s0(win_q[1]) + win_q[0];

  // Round t runs in the cycle after its schedule word is made.
  assign round_cnt = cnt_q - CntW'(1);
  assign round_idx = round_cnt[RoundW-1:0];
  assign t1 = v_q[7] + big_s1(v_q[4]) + ch_fn(v_q[4], v_q[5], v_q[6])
            + RoundK[round_idx] + w_q;
  assign t2 = big_s0(v_q[0]) + maj_fn(v_q[0], v_q[1], v_q[2]);

  always_comb begin
    for (int i = 0; i < DigestWords; i++) begin
      sum[i]      = chain_q[i] + v_q[i];
      digest_o[i] = sum[i];
    end
  end

  assign start = (state_q == CoreIdle) && q_stat_i.not_empty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CoreIdle: begin
        if (q_stat_i.not_empty) state_d = CoreRun;
      end
      CoreRun: begin
        if (cnt_q == CntW'(Rounds)) state_d = CoreAdd;
      end
      CoreAdd: begin
        if (!final_q || out_free_i) state_d = CoreIdle;
      end
      default: state_d = CoreIdle;
    endcase
  end

  always_comb begin
    q_rd_o.rd_en   = 1'b0;
    q_rd_o.rd_widx = '0;
    q_rd_o.pop     = 1'b0;
    out_load_o     = 1'b0;
    cnt_d          = cnt_q;
    unique case (state_q)
      CoreIdle: begin
        q_rd_o.rd_en = q_stat_i.not_empty;
        cnt_d        = '0;
      end
      CoreRun: begin
        // Fetch each word in the cycle before it is needed; release the slot after the last.
        q_rd_o.rd_en   = (cnt_q < CntW'(BlockWords - 1));
        q_rd_o.rd_widx = cnt_q[WidxW-1:0] + widx_t'(1);
        q_rd_o.pop     = (cnt_q == CntW'(BlockWords - 1));
        cnt_d          = cnt_q + CntW'(1);
      end
      CoreAdd: begin
        out_load_o = final_q && out_free_i;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CoreIdle;
      cnt_q   <= '0;
      final_q <= 1'b0;
      chain_q <= InitValue;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (start) begin
        final_q <= q_stat_i.head_final;
      end
      if (state_q == CoreAdd && state_d == CoreIdle) begin
        if (final_q) begin
          chain_q <= InitValue;
        end else begin
          chain_q <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      v_q <= chain_q;
    end
    if (state_q == CoreRun) begin
      if (cnt_q < CntW'(Rounds)) begin
        w_q <= w_new;
        for (int i = 0; i < BlockWords - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[BlockWords-1] <= w_new;
      end
      if (cnt_q != '0) begin
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
    end
  end

endmodule

### hw/rtl/sha256_bh_out.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash digest output
// Holds a finished digest and shifts it out one word per transfer.
// ----------------------------------------------------------------------------
module sha256_bh_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  sha256_bh_pkg::digest_t digest_i,
  output logic                   free_o,
  sha256_bh_out_if.source        dig_o
);
  import sha256_bh_pkg::*;

  localparam int unsigned IdxW = $clog2(DigestWords);

  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  digest_t         shift_q;
  logic            xfer;
  logic            last;

  assign xfer = dig_o.valid & dig_o.ready;
  assign last = (idx_q == IdxW'(DigestWords - 1));

  assign dig_o.valid       = busy_q;
  assign dig_o.digest_word = shift_q[0];
  assign dig_o.last_word   = last;
  assign free_o            = ~busy_q;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (xfer) begin
      idx_d = idx_q + IdxW'(1);
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shift_q <= digest_i;
    end else if (xfer) begin
      // Advance to the next digest word.
      shift_q <= {word_t'(0), shift_q[DigestWords-1:1]};
    end
  end

endmodule

### hw/rtl/sha256_block_hash_unit.sv
// Flow: a block's last word fills its queue slot; the idle core starts, fetches
//   and runs the rounds, adds, and for a final block loads the free output stage.
// Overlap: the front end fills the next queue slot while the single round unit
//   compresses a block; input stalls once all QueueDepth block slots are taken.
// Reset: chaining value returns to the SHA-256 initial value, queue and output empty.
// ----------------------------------------------------------------------------
// SHA-256 block hash unit
// Front end collects padded message words into queued block slots, the core
// compresses each block, and the output stage streams the eight digest words.
// ----------------------------------------------------------------------------
module sha256_block_hash_unit #(
  parameter int unsigned QueueDepth = sha256_bh_pkg::BlkQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sha256_bh_in_if.sink      msg_i,
  sha256_bh_out_if.source   dig_o
);
  import sha256_bh_pkg::*;

  q_wr_t   q_wr;
  q_rd_t   q_rd;
  q_stat_t q_stat;
  word_t   rd_data;
  logic    out_free;
  logic    out_load;
  digest_t digest;

  sha256_bh_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .msg_i    (msg_i),
    .q_stat_i (q_stat),
    .q_wr_o   (q_wr)
  );

  sha256_bh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_wr_i    (q_wr),
    .q_rd_i    (q_rd),
    .q_stat_o  (q_stat),
    .rd_data_o (rd_data)
  );

  sha256_bh_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .rd_data_i  (rd_data),
    .q_rd_o     (q_rd),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .digest_o   (digest)
  );

  sha256_bh_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .digest_i (digest),
    .free_o   (out_free),
    .dig_o    (dig_o)
  );

endmodule

### tb/sv/sha256_bh_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the message and digest channels. Every message word transfer is
// folded into a local copy of the chaining value and block buffer. The eight
// digest words of each final block are queued and compared, field by field,
// with the digest word transfers. It reports a mismatch count and the number
// of digest words still outstanding.
// ----------------------------------------------------------------------------
module sha256_bh_digest_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  sha256_bh_in_if         msg_mon,
  sha256_bh_out_if        dig_mon,
  output int unsigned     mismatch_count_o,
  output int unsigned     pending_count_o
);
  import sha256_bh_pkg::*;

  typedef struct packed {
    word_t digest_word;
    logic  last_word;
  } digest_beat_t;

  localparam word_t HashIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  word_t        chain_h [8];
  word_t        msg_block [16];
  widx_t        fill_idx;
  digest_beat_t digest_expected [$];
  int unsigned  mismatches = 0;
  int unsigned  outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = outstanding;

  function automatic word_t ror32(word_t x, int unsigned n);
    return word_t'({x, x} >> n);
  endfunction

  function automatic word_t bsig0(word_t x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic void restore_chain();
    for (int k = 0; k < 8; k++) chain_h[k] = HashIv[k];
  endfunction

  // Expand the schedule, run 64 rounds and add into the chaining value.
  function automatic void fold_block_into_chain();
    word_t sched [64];
    word_t va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
    for (int t = 0; t < 16; t++) sched[t] = msg_block[t];
    for (int t = 16; t < 64; t++) begin
      sched[t] = ssig1(sched[t-2]) + sched[t-7] + ssig0(sched[t-15]) + sched[t-16];
    end
    va = chain_h[0]; vb = chain_h[1]; vc = chain_h[2]; vd = chain_h[3];
    ve = chain_h[4]; vf = chain_h[5]; vg = chain_h[6]; vh = chain_h[7];
    for (int t = 0; t < 64; t++) begin
      t1 = vh + bsig1(ve) + ((ve & vf) ^ (~ve & vg)) + KTab[t] + sched[t];
      t2 = bsig0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    chain_h[0] += va; chain_h[1] += vb; chain_h[2] += vc; chain_h[3] += vd;
    chain_h[4] += ve; chain_h[5] += vf; chain_h[6] += vg; chain_h[7] += vh;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t exp_beat;
    if (!rst_ni) begin
      restore_chain();
      for (int k = 0; k < 16; k++) msg_block[k] = '0;
      fill_idx = '0;
      digest_expected.delete();
    end else begin
      if (dig_mon.valid && dig_mon.ready) begin
        if (digest_expected.size() == 0) begin
          $error("unexpected digest transfer: digest_word %08h last_word %0b",
                 dig_mon.digest_word, dig_mon.last_word);
          mismatches++;
        end else begin
          exp_beat = digest_expected.pop_front();
          if (dig_mon.digest_word !== exp_beat.digest_word) begin
            $error("digest_word mismatch: expected %08h, actual %08h",
                   exp_beat.digest_word, dig_mon.digest_word);
            mismatches++;
          end
          if (dig_mon.last_word !== exp_beat.last_word) begin
            $error("last_word mismatch: expected %0b, actual %0b",
                   exp_beat.last_word, dig_mon.last_word);
            mismatches++;
          end
        end
      end
      if (msg_mon.valid && msg_mon.ready) begin
        msg_block[fill_idx] = msg_mon.message_word;
        fill_idx = fill_idx + widx_t'(1);
        // Only the flag on the sixteenth word of a block matters.
        if (fill_idx == '0) begin
          fold_block_into_chain();
          if (msg_mon.final_block) begin
            for (int k = 0; k < 8; k++) begin
              exp_beat.digest_word = chain_h[k];
              exp_beat.last_word   = (k == 7);
              digest_expected.push_back(exp_beat);
            end
            restore_chain();
          end
        end
      end
    end
    outstanding = digest_expected.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 block hash unit testbench
// Feeds messages of one to four blocks, a directed pair of blocks first, then
// random content with stray final flags, across phases of sender idling and
// receiver stalling, including one long receiver hold-off. The checker
// predicts every digest word; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import sha256_bh_pkg::*;

  localparam int unsigned HalfPeriodNs  = 6;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned PhaseItems    = 120;
  localparam int unsigned HoldOffCycles = 500;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainLimit    = 20000;
  localparam int unsigned TailCycles    = 100;

  localparam int unsigned SendIdlePct [4] = '{0, 79, 0, 32};
  localparam int unsigned RecvStallPct [4] = '{0, 0, 79, 32};

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_request = 1'b0;

  sha256_bh_in_if  msg_ch ();
  sha256_bh_out_if dig_ch ();

  sha256_block_hash_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .msg_i  (msg_ch),
    .dig_o  (dig_ch)
  );

  sha256_bh_digest_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .msg_mon          (msg_ch),
    .dig_mon          (dig_ch),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #(HalfPeriodNs) clk = ~clk;
  end

  // Offer one word, idling first at the current rate; return after the transfer.
  task automatic send_word(input word_t w, input logic fin);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid        <= 1'b1;
    msg_ch.message_word <= w;
    msg_ch.final_block  <= fin;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_message(input int unsigned n_blocks);
    word_t       w;
    logic        fin;
    int unsigned pick;
    for (int b = 0; b < n_blocks; b++) begin
      for (int i = 0; i < 16; i++) begin
        pick = $urandom_range(7, 0);
        w    = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : word_t'($urandom());
        // Stray flags on words 0 to 14 must be ignored.
        fin  = (i == 15) ? (b == n_blocks - 1) : ($urandom_range(3, 0) == 0);
        send_word(w, fin);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    dig_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        dig_ch.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        dig_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run after too many cycles with no transfer at all.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned phase_end;
    int unsigned drain_cycles;
    int unsigned n_blocks;
    rst_n               = 1'b0;
    msg_ch.valid        = 1'b0;
    msg_ch.message_word = '0;
    msg_ch.final_block  = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SendIdlePct[p];
      recv_stall_pct = RecvStallPct[p];
      phase_end      = words_sent + PhaseItems;
      if (p == 0) begin
        // Non-final block of extreme words with the flag set on words 0 to 14.
        for (int i = 0; i < 16; i++) send_word(i[0] ? 32'hffff_ffff : 32'h0, i != 15);
        // Padded "abc" block closing the message, flag only on the last word.
        for (int i = 0; i < 16; i++) begin
          send_word((i == 0) ? 32'h6162_6380 : (i == 15) ? 32'h18 : 32'h0, i == 15);
        end
        hold_request = 1'b1;
      end
      while (words_sent < phase_end) begin
        n_blocks = ($urandom_range(9, 0) < 7) ? $urandom_range(2, 1) : $urandom_range(4, 3);
        send_message(n_blocks);
      end
    end
    msg_ch.valid <= 1'b0;
    // Let the checker take in the last word transfer before reading its count.
    @(posedge clk);

    drain_cycles = 0;
    while (pending_count != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sha256_bh_pkg.sv
hw/rtl/sha256_bh_if.sv
hw/rtl/sha256_bh_front.sv
hw/rtl/sha256_bh_queue.sv
hw/rtl/sha256_bh_core.sv
hw/rtl/sha256_bh_out.sv
hw/rtl/sha256_block_hash_unit.sv
tb/sv/sha256_bh_digest_checker.sv
tb/sv/testbench.sv
